FILE: rtl/thk_pkg.sv
`default_nettype none

package thk_pkg;

    // Event type codes
    localparam logic [4:0] TYPE_SYNC = 5'd0;
    localparam logic [4:0] TYPE_KEY  = 5'd1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_W      = 10;
    localparam int STEP_W     = 3;

    localparam int BUF_DEPTH_DEF = 32;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODIFIER_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODIFIER_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODIFIER_C   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODIFIER_D   = 3'd7;

    // Register reset values
    localparam logic [15:0]      RST_HOLD_TICKS   = 16'd300;
    localparam logic [KEY_W-1:0] RST_TRIGGER_CODE = 10'd58;
    localparam logic [KEY_W-1:0] RST_TAP_CODE     = 10'd1;
    localparam logic [KEY_W-1:0] RST_TOGGLE_CODE  = 10'd58;
    localparam logic [KEY_W-1:0] RST_MODIFIER_A   = 10'd125;
    localparam logic [KEY_W-1:0] RST_MODIFIER_B   = 10'd29;
    localparam logic [KEY_W-1:0] RST_MODIFIER_C   = 10'd56;
    localparam logic [KEY_W-1:0] RST_MODIFIER_D   = 10'd42;

    // Generated sequence selected by one evaluated item
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_PASS   = 3'd1,
        K_TOGGLE = 3'd2,
        K_TAP    = 3'd3,
        K_DOWN   = 3'd4,
        K_UP     = 3'd5
    } kind_t;

    typedef struct packed {
        logic              capture;
        logic              eval;
        logic              load_gen;
        logic [STEP_W-1:0] step;
        logic              rd;
        logic              load_rp;
        logic              rp_inc;
    } cmd_t;

    typedef struct packed {
        logic emits;
        logic out_free;
        logic gen_last;
        logic rp_any;
        logic rp_last;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/tap_hold_key_remapper.sv
`default_nettype none

// Dual-role key remapper. Items are input events (func = 0) or one-millisecond
// ticks (func = 1). One item is handled at a time: it is taken and evaluated,
// then each generated event (passthrough, tap, toggle or the four modifiers
// plus sync) is loaded into the output register as soon as that is free,
// and each replayed buffered event is a registered read of the buffer RAM
// followed by a load of the output register. The longest run follows a hold
// decision with a full buffer, and out_ready held low stretches any run. An
// item with no result returns to idle straight from evaluation. The output
// register lets a new item be taken while the last result of the previous
// one still waits. Config registers are written through cfg_we/cfg_idx/cfg_data
// and take effect at once; write them only while the block is idle. No buffer
// clearing pass is needed after reset.

module tap_hold_key_remapper
    import thk_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic                  func,
    input  wire logic [4:0]            ev_type,
    input  wire logic [KEY_W-1:0]      ev_code,
    input  wire logic signed [31:0]    ev_value,
    // output channel
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [4:0]            out_type,
    output      logic [KEY_W-1:0]      out_code,
    output      logic signed [31:0]    out_value,
    output      logic                  last
);
    cmd_t    cmd;
    status_t st;

    // Sequencer: idle / evaluate / generate / buffer read / replay transfer
    thk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Window state, config, held-event buffer and output register
    thk_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .func      (func),
        .ev_type   (ev_type),
        .ev_code   (ev_code),
        .ev_value  (ev_value),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_type  (out_type),
        .out_code  (out_code),
        .out_value (out_value),
        .last      (last),
        .cmd       (cmd),
        .st        (st)
    );

    // An accepted item is evaluated before another can be taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.eval))
        else $error("input taken again before evaluation");

    // The output register is only loaded when its content is gone or leaving
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_gen || cmd.load_rp) |-> st.out_free)
        else $error("output register overwritten");

    // Generation and replay never load together, and never while idle
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_gen && cmd.load_rp) && !(in_ready && (cmd.load_gen || cmd.load_rp)))
        else $error("conflicting output loads");

endmodule

`default_nettype wire

FILE: rtl/thk_ram.sv
`default_nettype none

module thk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output      logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/thk_datapath.sv
`default_nettype none

module thk_datapath
    import thk_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input payload
    input  wire logic                  func,
    input  wire logic [4:0]            ev_type,
    input  wire logic [KEY_W-1:0]      ev_code,
    input  wire logic signed [31:0]    ev_value,
    // output
    input  wire logic                  out_ready,
    output      logic                  out_valid,
    output      logic [4:0]            out_type,
    output      logic [KEY_W-1:0]      out_code,
    output      logic signed [31:0]    out_value,
    output      logic                  last,
    // control
    input  wire cmd_t                  cmd,
    output      status_t               st
);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int EW = 5 + KEY_W + 32;

    // config registers
    logic [15:0]      hold_ticks_reg;
    logic [KEY_W-1:0] trigger_code_reg, tap_code_reg, toggle_code_reg;
    logic [KEY_W-1:0] mod_a_reg, mod_b_reg, mod_c_reg, mod_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg   <= RST_HOLD_TICKS;
            trigger_code_reg <= RST_TRIGGER_CODE;
            tap_code_reg     <= RST_TAP_CODE;
            toggle_code_reg  <= RST_TOGGLE_CODE;
            mod_a_reg        <= RST_MODIFIER_A;
            mod_b_reg        <= RST_MODIFIER_B;
            mod_c_reg        <= RST_MODIFIER_C;
            mod_d_reg        <= RST_MODIFIER_D;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                REG_TRIGGER_CODE: trigger_code_reg <= cfg_data[KEY_W-1:0];
                REG_TAP_CODE:     tap_code_reg     <= cfg_data[KEY_W-1:0];
                REG_TOGGLE_CODE:  toggle_code_reg  <= cfg_data[KEY_W-1:0];
                REG_MODIFIER_A:   mod_a_reg        <= cfg_data[KEY_W-1:0];
                REG_MODIFIER_B:   mod_b_reg        <= cfg_data[KEY_W-1:0];
                REG_MODIFIER_C:   mod_c_reg        <= cfg_data[KEY_W-1:0];
                REG_MODIFIER_D:   mod_d_reg        <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic                cap_func_reg;
    logic [4:0]          cap_type_reg;
    logic [KEY_W-1:0]    cap_code_reg;
    logic signed [31:0]  cap_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_func_reg  <= func;
            cap_type_reg  <= ev_type;
            cap_code_reg  <= ev_code;
            cap_value_reg <= ev_value;
        end
    end

    // window state
    logic          open_reg, open_next;
    logic          decided_reg, decided_next;
    logic          mods_reg, mods_next;
    logic [1:0]    pc_reg, pc_next;
    logic [1:0]    rc_reg, rc_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic [CW-1:0] hc_reg, hc_next;
    kind_t         kind_reg, kind_next;
    logic [CW-1:0] rp_len_reg, rp_len_next;
    logic [CW-1:0] rp_idx_reg;

    logic        buf_we;
    logic        do_close;
    logic        is_trig;
    logic [15:0] el_inc;

    always_comb
    begin
        open_next    = open_reg;
        decided_next = decided_reg;
        mods_next    = mods_reg;
        pc_next      = pc_reg;
        rc_next      = rc_reg;
        elapsed_next = elapsed_reg;
        hc_next      = hc_reg;
        kind_next    = K_NONE;
        rp_len_next  = '0;
        buf_we       = 1'b0;
        do_close     = 1'b0;
        is_trig      = !cap_func_reg && cap_type_reg == TYPE_KEY
                       && cap_code_reg == trigger_code_reg;
        el_inc       = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

        if (cap_func_reg)
        begin
            if (open_reg && !decided_reg)
            begin
                elapsed_next = el_inc;
                if (el_inc >= hold_ticks_reg)
                begin
                    if (pc_reg >= 2'd2 && rc_reg >= 2'd1)
                    begin
                        kind_next = K_TOGGLE;
                        do_close  = 1'b1;
                    end
                    else if (pc_reg == 2'd1 && rc_reg == 2'd1)
                    begin
                        kind_next   = K_TAP;
                        rp_len_next = hc_reg;
                        do_close    = 1'b1;
                    end
                    else if (pc_reg == 2'd1 && rc_reg == 2'd0)
                    begin
                        kind_next    = K_DOWN;
                        rp_len_next  = hc_reg;
                        mods_next    = 1'b1;
                        decided_next = 1'b1;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                    end
                end
            end
        end
        else if (is_trig)
        begin
            if (!open_reg)
            begin
                open_next    = 1'b1;
                elapsed_next = '0;
            end
            if (cap_value_reg == 32'sd1)
            begin
                if (pc_reg != 2'd3)
                begin
                    pc_next = pc_reg + 2'd1;
                end
            end
            else if (cap_value_reg == 32'sd0)
            begin
                if (rc_reg != 2'd3)
                begin
                    rc_next = rc_reg + 2'd1;
                end
                if (mods_reg)
                begin
                    kind_next = K_UP;
                    mods_next = 1'b0;
                end
                do_close = decided_reg;
            end
        end
        else if (open_reg && !decided_reg && hc_reg < CW'(BUFFER_DEPTH))
        begin
            buf_we  = cmd.eval;
            hc_next = hc_reg + CW'(1);
        end
        else
        begin
            kind_next = K_PASS;
        end

        if (do_close)
        begin
            open_next    = 1'b0;
            decided_next = 1'b0;
            pc_next      = '0;
            rc_next      = '0;
            hc_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            decided_reg <= 1'b0;
            mods_reg    <= 1'b0;
            pc_reg      <= '0;
            rc_reg      <= '0;
            elapsed_reg <= '0;
            hc_reg      <= '0;
            kind_reg    <= K_NONE;
            rp_len_reg  <= '0;
            rp_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                open_reg    <= open_next;
                decided_reg <= decided_next;
                mods_reg    <= mods_next;
                pc_reg      <= pc_next;
                rc_reg      <= rc_next;
                elapsed_reg <= elapsed_next;
                hc_reg      <= hc_next;
                kind_reg    <= kind_next;
                rp_len_reg  <= rp_len_next;
                rp_idx_reg  <= '0;
            end
            else if (cmd.rp_inc)
            begin
                rp_idx_reg <= rp_idx_reg + CW'(1);
            end
        end
    end

    // held event buffer
    logic [EW-1:0] rd_data;

    thk_ram #(
        .WIDTH (EW),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (hc_reg[AW-1:0]),
        .wdata ({cap_type_reg, cap_code_reg, cap_value_reg}),
        .re    (cmd.rd),
        .raddr (rp_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // generated event for current step
    logic [4:0]         gen_type;
    logic [KEY_W-1:0]   gen_code;
    logic signed [31:0] gen_value;
    logic [KEY_W-1:0]   mod_sel;
    logic               gen_last;

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0:    mod_sel = mod_a_reg;
            2'd1:    mod_sel = mod_b_reg;
            2'd2:    mod_sel = mod_c_reg;
            default: mod_sel = mod_d_reg;
        endcase

        gen_type  = TYPE_SYNC;
        gen_code  = '0;
        gen_value = '0;
        gen_last  = 1'b1;
        case (kind_reg) inside
            K_PASS:
            begin
                gen_type  = cap_type_reg;
                gen_code  = cap_code_reg;
                gen_value = cap_value_reg;
                gen_last  = (cmd.step == STEP_W'(0));
            end
            K_TOGGLE, K_TAP:
            begin
                if (cmd.step < STEP_W'(2))
                begin
                    gen_type  = TYPE_KEY;
                    gen_code  = (kind_reg == K_TAP) ? tap_code_reg : toggle_code_reg;
                    gen_value = (cmd.step == STEP_W'(0)) ? 32'sd1 : 32'sd0;
                end
                gen_last = (cmd.step == STEP_W'(2));
            end
            K_DOWN, K_UP:
            begin
                if (cmd.step < STEP_W'(4))
                begin
                    gen_type  = TYPE_KEY;
                    gen_code  = mod_sel;
                    gen_value = (kind_reg == K_DOWN) ? 32'sd1 : 32'sd0;
                end
                gen_last = (cmd.step == STEP_W'(4));
            end
            default: ;
        endcase
    end

    // output register
    logic               out_valid_reg;
    logic [4:0]         out_type_reg;
    logic [KEY_W-1:0]   out_code_reg;
    logic signed [31:0] out_value_reg;
    logic               last_reg;
    logic               rp_last;

    assign rp_last = (rp_idx_reg + CW'(1) == rp_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_gen || cmd.load_rp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_gen)
        begin
            out_type_reg  <= gen_type;
            out_code_reg  <= gen_code;
            out_value_reg <= gen_value;
            last_reg      <= gen_last && rp_len_reg == '0;
        end
        else if (cmd.load_rp)
        begin
            out_type_reg  <= rd_data[EW-1 -: 5];
            out_code_reg  <= rd_data[31+KEY_W -: KEY_W];
            out_value_reg <= rd_data[31:0];
            last_reg      <= rp_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_type  = out_type_reg;
    assign out_code  = out_code_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    assign st.emits    = (kind_next != K_NONE);
    assign st.out_free = !out_valid_reg || out_ready;
    assign st.gen_last = gen_last;
    assign st.rp_any   = (rp_len_reg != '0);
    assign st.rp_last  = rp_last;

endmodule

`default_nettype wire

FILE: rtl/thk_ctrl.sv
`default_nettype none

module thk_ctrl
    import thk_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire status_t st,
    output      cmd_t    cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_GEN  = 5'b00100,
        S_RD   = 5'b01000,
        S_RP   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        in_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval  = 1'b1;
                step_next = '0;
                state_next = st.emits ? S_GEN : S_IDLE;
            end
            S_GEN:
            begin
                if (st.out_free)
                begin
                    cmd.load_gen = 1'b1;
                    if (st.gen_last)
                    begin
                        state_next = st.rp_any ? S_RD : S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + STEP_W'(1);
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_RP;
            end
            S_RP:
            begin
                if (st.out_free)
                begin
                    cmd.load_rp = 1'b1;
                    if (st.rp_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rp_inc = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_tap_hold_key_remapper.sv
`timescale 1ns / 100ps

module tb_tap_hold_key_remapper
    import thk_pkg::*;
;

    // Timeout for about 450 items plus idling, settles and register writes.
    localparam int LIMIT_CYCLES  = 2_000_000;
    // Settle for longer than the worst burst, a hold decision with a full buffer.
    localparam int SETTLE_CYCLES = 100;
    localparam int IDLE_PCT      = 18;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_PHASES   = 6;
    localparam int PHASE_ITEMS   = 52;

    // One input item as it goes over the input channel
    typedef struct packed {
        logic              f;
        logic [4:0]        t;
        logic [KEY_W-1:0]  c;
        logic [31:0]       v;
    } key_item_t;

    // One emitted event as it is expected on the output channel
    typedef struct packed {
        logic [4:0]        t;
        logic [KEY_W-1:0]  c;
        logic [31:0]       v;
        logic              last;
    } out_event_t;

    // ------------------------------------------------------------------
    // DUT signals; everything the TB drives starts at a known value
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = 1'b0;
    logic [4:0]            ev_type = '0;
    logic [KEY_W-1:0]      ev_code = '0;
    logic signed [31:0]    ev_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [4:0]            out_type;
    logic [KEY_W-1:0]      out_code;
    logic signed [31:0]    out_value;
    logic                  last;

    tap_hold_key_remapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .ev_type   (ev_type),
        .ev_code   (ev_code),
        .ev_value  (ev_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_type  (out_type),
        .out_code  (out_code),
        .out_value (out_value),
        .last      (last)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    key_item_t   pending_items[$];    // filled by the stimulus, drained by the driver
    out_event_t  expected_events[$];  // predicted output, oldest first
    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;    // input transfers seen by the driver
    int unsigned fail_count   = 0;
    int unsigned cycles       = 0;
    logic        steady;              // no idling on either side in this stretch

    // Stretches where bits 11:10 of the cycle count equal 1 have both sides always willing
    assign steady = (((cycles >> 10) & 3) == 1);

    // ------------------------------------------------------------------
    // Predictor state: register mirror plus the remapper's own state
    // ------------------------------------------------------------------
    logic [15:0]      cfg_hold    = RST_HOLD_TICKS;
    logic [KEY_W-1:0] cfg_trigger = RST_TRIGGER_CODE;
    logic [KEY_W-1:0] cfg_tap     = RST_TAP_CODE;
    logic [KEY_W-1:0] cfg_toggle  = RST_TOGGLE_CODE;
    logic [KEY_W-1:0] cfg_mod [4] = '{RST_MODIFIER_A, RST_MODIFIER_B,
                                      RST_MODIFIER_C, RST_MODIFIER_D};

    logic        win_open    = 1'b0;
    logic        win_decided = 1'b0;
    logic        mods_down   = 1'b0;
    logic [1:0]  presses     = '0;    // saturate at 3
    logic [1:0]  releases    = '0;
    logic [15:0] tick_count  = '0;    // saturates at all ones
    key_item_t   held [BUF_DEPTH_DEF];
    int          held_count  = 0;
    int          burst_len;           // events emitted by the item being predicted

    task automatic push_event(input logic [4:0] t, input logic [KEY_W-1:0] c,
                              input logic [31:0] v);
        out_event_t e;
        e.t = t;
        e.c = c;
        e.v = v;
        e.last = 1'b0;
        expected_events.push_back(e);
        burst_len++;
    endtask

    // four modifiers with one value, then a sync
    task automatic send_mods(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            push_event(TYPE_KEY, cfg_mod[i], v);
        push_event(TYPE_SYNC, '0, '0);
    endtask

    task automatic replay_held();
        for (int i = 0; i < held_count; i++)
            push_event(held[i].t, held[i].c, held[i].v);
    endtask

    task automatic close_window();
        win_open    = 1'b0;
        win_decided = 1'b0;
        presses     = '0;
        releases    = '0;
        held_count  = 0;
    endtask

    // Advance the remapper by one accepted item and queue what it emits
    task automatic remap_event(input key_item_t it);
        out_event_t tail;
        burst_len = 0;
        if (it.f)
        begin
            // tick: only counts inside an undecided window
            if (win_open && !win_decided)
            begin
                if (tick_count != 16'hFFFF)
                    tick_count = tick_count + 16'd1;
                if (tick_count >= cfg_hold)
                begin
                    if (presses >= 2 && releases >= 1)
                    begin
                        // double tap: toggle key, buffer dropped
                        push_event(TYPE_KEY, cfg_toggle, 32'd1);
                        push_event(TYPE_KEY, cfg_toggle, 32'd0);
                        push_event(TYPE_SYNC, '0, '0);
                        close_window();
                    end
                    else if (presses == 1 && releases == 1)
                    begin
                        push_event(TYPE_KEY, cfg_tap, 32'd1);
                        push_event(TYPE_KEY, cfg_tap, 32'd0);
                        push_event(TYPE_SYNC, '0, '0);
                        replay_held();
                        close_window();
                    end
                    else if (presses == 1 && releases == 0)
                    begin
                        // hold: modifiers go down, buffer replayed, window stays
                        send_mods(32'd1);
                        replay_held();
                        mods_down   = 1'b1;
                        win_decided = 1'b1;
                    end
                    else
                    begin
                        // counts that fit no pattern: decided, silent
                        win_decided = 1'b1;
                    end
                end
            end
        end
        else if (it.t == TYPE_KEY && it.c == cfg_trigger)
        begin
            if (!win_open)
            begin
                win_open   = 1'b1;
                tick_count = '0;
            end
            if (it.v == 32'd1)
            begin
                if (presses != 2'd3)
                    presses = presses + 2'd1;
            end
            else if (it.v == 32'd0)
            begin
                if (releases != 2'd3)
                    releases = releases + 2'd1;
                if (mods_down)
                begin
                    send_mods(32'd0);
                    mods_down = 1'b0;
                end
                if (win_decided)
                    close_window();
            end
        end
        else if (win_open && !win_decided && held_count < BUF_DEPTH_DEF)
        begin
            held[held_count] = it;
            held_count++;
        end
        else
        begin
            push_event(it.t, it.c, it.v);
        end
        if (burst_len > 0)
        begin
            tail = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items, predicts on each input transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        key_item_t nxt;
        key_item_t cur;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cur.f = func;
                cur.t = ev_type;
                cur.c = ev_code;
                cur.v = ev_value;
                remap_event(cur);
                items_taken++;
            end
            // a presented item is held until its transfer
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    func     <= nxt.f;
                    ev_type  <= nxt.t;
                    ev_code  <= nxt.c;
                    ev_value <= nxt.v;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each output transfer against the oldest expectation
    // Reports list type/code/value/last.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_event_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR: unexpected %0d/%0d/%0d/%0b",
                                 out_type, out_code, out_value, last);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_type !== want.t || out_code !== want.c ||
                        out_value !== want.v || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("ERROR: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     want.t, want.c, $signed(want.v), want.last,
                                     out_type, out_code, out_value, last);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic f, input logic [4:0] t,
                            input logic [KEY_W-1:0] c, input logic [31:0] v);
        key_item_t it;
        it.f = f;
        it.t = t;
        it.c = c;
        it.v = v;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic add_key(input logic [KEY_W-1:0] c, input logic [31:0] v);
        add_item(1'b0, TYPE_KEY, c, v);
    endtask

    // ticks carry junk in the event fields, which the block must ignore
    task automatic add_ticks(input int n);
        repeat (n)
            add_item(1'b1, 5'($urandom_range(31)), KEY_W'($urandom_range(767)), $urandom);
    endtask

    // any event that is not the trigger key
    task automatic add_other();
        logic [4:0]       t;
        logic [KEY_W-1:0] c;
        logic [31:0]      v;
        t = ($urandom_range(1) == 0) ? TYPE_KEY : 5'($urandom_range(31));
        do
            c = KEY_W'($urandom_range(767));
        while (t == TYPE_KEY && c == cfg_trigger);
        v = ($urandom_range(2) == 0) ? $urandom : 32'($urandom_range(2));
        add_item(1'b0, t, c, v);
    endtask

    // One gesture of the trigger key with random filler; mostly well formed,
    // some noise. Filler is occasionally long enough to overflow the buffer.
    task automatic add_burst();
        int kind;
        int n;
        int need;
        kind = $urandom_range(9);
        n    = ($urandom_range(7) == 0) ? $urandom_range(36, 28) : $urandom_range(4);
        need = (cfg_hold == 0) ? 1 : cfg_hold;
        case (kind)
            0, 1:                                   // single tap
            begin
                add_key(cfg_trigger, 32'd1);
                repeat (n) add_other();
                add_key(cfg_trigger, 32'd0);
                add_ticks(need + $urandom_range(2));
            end
            2:                                      // double (or triple) tap
            begin
                add_key(cfg_trigger, 32'd1);
                add_key(cfg_trigger, 32'd0);
                repeat (n) add_other();
                add_key(cfg_trigger, 32'd1);
                if ($urandom_range(1)) add_key(cfg_trigger, 32'd0);
                if ($urandom_range(3) == 0) add_key(cfg_trigger, 32'd1);
                add_ticks(need + $urandom_range(2));
            end
            3, 4:                                   // hold
            begin
                add_key(cfg_trigger, 32'd1);
                if ($urandom_range(1)) add_key(cfg_trigger, 32'd2);
                repeat (n) add_other();
                add_ticks(need + $urandom_range(2));
                repeat ($urandom_range(3)) add_other();
                if ($urandom_range(1)) add_key(cfg_trigger, 32'd1);
                add_key(cfg_trigger, 32'd0);
            end
            5:                                      // no clean pattern
            begin
                if ($urandom_range(1))
                begin
                    add_key(cfg_trigger, 32'd0);
                end
                else
                begin
                    add_key(cfg_trigger, 32'd1);
                    add_key(cfg_trigger, 32'd1);
                end
                repeat (n) add_other();
                add_ticks(need);
                add_other();
                add_key(cfg_trigger, 32'd0);
            end
            6:                                      // odd value opens, then a tap
            begin
                add_key(cfg_trigger, $urandom);
                add_key(cfg_trigger, 32'd1);
                add_other();
                add_key(cfg_trigger, 32'd0);
                add_ticks(need);
            end
            default:                                // noise
            begin
                repeat ($urandom_range(8, 2))
                begin
                    case ($urandom_range(3))
                        0: add_ticks(1);
                        1: add_other();
                        2: add_key(cfg_trigger, $urandom_range(2));
                        default: add_key(KEY_W'($urandom_range(767)), $urandom);
                    endcase
                end
            end
        endcase
    endtask

    // all items taken, all results seen, then let the block settle
    task automatic wait_drained();
        while (items_taken != items_queued || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_HOLD_TICKS:   cfg_hold    = data;
            REG_TRIGGER_CODE: cfg_trigger = data[KEY_W-1:0];
            REG_TAP_CODE:     cfg_tap     = data[KEY_W-1:0];
            REG_TOGGLE_CODE:  cfg_toggle  = data[KEY_W-1:0];
            REG_MODIFIER_A:   cfg_mod[0]  = data[KEY_W-1:0];
            REG_MODIFIER_B:   cfg_mod[1]  = data[KEY_W-1:0];
            REG_MODIFIER_C:   cfg_mod[2]  = data[KEY_W-1:0];
            default:          cfg_mod[3]  = data[KEY_W-1:0];
        endcase
    endtask

    // new setting for every register, only once the block is idle
    task automatic set_config(input logic [15:0] hold, input logic [KEY_W-1:0] trig,
                              input logic [KEY_W-1:0] tap, input logic [KEY_W-1:0] tog,
                              input logic [KEY_W-1:0] ma, input logic [KEY_W-1:0] mb,
                              input logic [KEY_W-1:0] mc, input logic [KEY_W-1:0] md);
        wait_drained();
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_TRIGGER_CODE, CFG_DATA_W'(trig));
        write_reg(REG_TAP_CODE, CFG_DATA_W'(tap));
        write_reg(REG_TOGGLE_CODE, CFG_DATA_W'(tog));
        write_reg(REG_MODIFIER_A, CFG_DATA_W'(ma));
        write_reg(REG_MODIFIER_B, CFG_DATA_W'(mb));
        write_reg(REG_MODIFIER_C, CFG_DATA_W'(mc));
        write_reg(REG_MODIFIER_D, CFG_DATA_W'(md));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: no window yet, so everything passes through and
        // ticks are dropped. Field extremes.
        add_item(1'b0, 5'd31, 10'd767, 32'h7FFF_FFFF);
        add_item(1'b0, TYPE_SYNC, '0, 32'h8000_0000);
        add_item(1'b0, TYPE_SYNC, '0, '0);
        add_key(10'd5, 32'd1);
        add_ticks(1);
        add_item(1'b1, 5'd31, 10'd767, 32'hFFFF_FFFF);

        // Short hold time: one of each gesture
        set_config(16'd2, RST_TRIGGER_CODE, RST_TAP_CODE, RST_TOGGLE_CODE,
                   RST_MODIFIER_A, RST_MODIFIER_B, RST_MODIFIER_C, RST_MODIFIER_D);
        // tap with one buffered event replayed after it
        add_key(cfg_trigger, 32'd1);
        add_key(10'd30, 32'd1);
        add_key(cfg_trigger, 32'd0);
        add_ticks(2);
        // double tap, buffer dropped
        add_key(cfg_trigger, 32'd1);
        add_key(cfg_trigger, 32'd0);
        add_key(10'd31, 32'd0);
        add_key(cfg_trigger, 32'd1);
        add_key(cfg_trigger, 32'd0);
        add_ticks(2);
        // hold: mods down, passthrough while held, extra press only counted,
        // late tick ignored, release sends mods up
        add_key(cfg_trigger, 32'd1);
        add_key(10'd32, 32'd1);
        add_ticks(2);
        add_key(10'd33, 32'd1);
        add_ticks(1);
        add_key(cfg_trigger, 32'd1);
        add_key(cfg_trigger, 32'd0);
        // repeat value opens the window; release with no press is undecidable
        add_key(cfg_trigger, 32'd2);
        add_key(cfg_trigger, 32'd0);
        add_ticks(2);
        add_key(10'd34, 32'd2);
        add_key(cfg_trigger, 32'd0);

        // Zero hold time: first tick of the window decides
        set_config(16'd0, 10'd100, 10'd101, 10'd102, 10'd1, 10'd2, 10'd3, 10'd4);
        add_key(cfg_trigger, 32'd1);
        add_ticks(1);
        add_key(cfg_trigger, 32'd0);

        // Random settings with small hold times
        for (int p = 0; p < HOLD_PHASES; p++)
        begin
            set_config(16'($urandom_range(6, 1)),
                       ($urandom_range(1) != 0) ? RST_TRIGGER_CODE
                                                : KEY_W'($urandom_range(767)),
                       KEY_W'($urandom_range(767)), KEY_W'($urandom_range(767)),
                       KEY_W'($urandom_range(767)), KEY_W'($urandom_range(767)),
                       KEY_W'($urandom_range(767)), KEY_W'($urandom_range(767)));
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS)
                add_burst();
        end

        // All codes at 767, hold time at its maximum: the window stays
        // undecided and its buffer carries over into the next setting
        set_config(16'hFFFF, 10'd767, 10'd767, 10'd767, 10'd767, 10'd767, 10'd767, 10'd767);
        add_key(cfg_trigger, 32'd1);
        repeat (3) add_other();
        add_ticks(3);
        add_other();
        add_key(cfg_trigger, 32'd0);

        // All codes at zero, hold time of one tick
        set_config(16'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        start = items_queued;
        while (items_queued - start < PHASE_ITEMS)
            add_burst();

        wait_drained();
        if (fail_count == 0 && expected_events.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: tap_hold_key_remapper.f
rtl/thk_pkg.sv
rtl/thk_ram.sv
rtl/thk_datapath.sv
rtl/thk_ctrl.sv
rtl/tap_hold_key_remapper.sv
verif/tb_tap_hold_key_remapper.sv
